FILE: src/ipacl_pkg.sv
// Shared types, codes and the prefix mask helper of the IP allow/deny access list.
package ipacl_pkg;

    localparam int ADDR_W   = 128;
    localparam int HIT_W    = 4;
    localparam int SLOT_W   = 4;
    localparam int PLEN_W   = 8;
    localparam int CMD_W    = 2;
    localparam int VERD_W   = 2;
    localparam int S_DATA_W = 280;
    localparam int M_DATA_W = 8;

    localparam logic [PLEN_W-1:0] V4_MAX_PLEN = 8'd32;
    localparam logic [PLEN_W-1:0] V6_MAX_PLEN = 8'd128;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

    localparam logic [VERD_W-1:0] VERDICT_DEFAULT = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_ALLOW   = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_DENY    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // One stored rule, kept as a single memory row.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic              is_ipv4;
        logic              allow;
        logic              all_scope;
    } rule_t;

    typedef struct packed {
        logic              allowed;
        logic [VERD_W-1:0] verdict;
        logic [HIT_W-1:0]  hit_index;
    } result_t;

    // Mask with the clamped prefix length as leading ones.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen,
                                                      input logic is_ipv4);
        logic [PLEN_W-1:0] lim;
        logic [PLEN_W-1:0] n;
        lim = is_ipv4 ? V4_MAX_PLEN : V6_MAX_PLEN;
        n   = (plen > lim) ? lim : plen;
        return (n == V6_MAX_PLEN) ? {ADDR_W{1'b1}} : ~({ADDR_W{1'b1}} >> n);
    endfunction

endpackage

FILE: src/ipacl_rule_mem.sv
// Rule storage memory with one write port and one registered read port.
module ipacl_rule_mem #(
    parameter int RULES = 16,
    parameter int IDX_W = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  ipacl_pkg::rule_t    wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output ipacl_pkg::rule_t    rd_data
);

    ipacl_pkg::rule_t mem [RULES];
    ipacl_pkg::rule_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ipacl_match.sv
// Shared compare unit: tests one rule against the queried address.
module ipacl_match (
    input  ipacl_pkg::rule_t                  rule,
    input  logic [ipacl_pkg::ADDR_W-1:0]      query,
    input  logic                              slot_valid,
    input  logic                              only_all,
    output logic                              hit
);

    logic [ipacl_pkg::ADDR_W-1:0] diff;
    logic                         addr_eq;

    assign diff = (rule.addr ^ query) & rule.mask;

    // An IPv4 rule looks only at the top four address bytes.
    assign addr_eq = rule.is_ipv4 ? (diff[ipacl_pkg::ADDR_W-1 -: 32] == 32'd0)
                                  : (diff == '0);

    assign hit = slot_valid && (!only_all || rule.all_scope) && addr_eq;

endmodule

FILE: src/ip_allow_deny_access_list.sv
// IP allow/deny access list with a rule table that is scanned in full for every check.
// A check reads one rule per cycle from the rule memory through a single compare unit,
// so one check occupies the block for the whole table scan; clear and write do not scan.
// The block takes no new transfer while an item is in progress, but a finished result
// waiting in the output register does not hold off the next input transfer.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
module ip_allow_deny_access_list #(
    parameter int RULES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata fields from bit 0 up: rule_index[3:0], addr_hi[63:0], addr_lo[63:0],
    // mask_hi[63:0], mask_lo[63:0], use_prefix, prefix_len[7:0], rule_is_ipv4,
    // rule_allow, rule_all_scope, query_all_scope, zero fill.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ipacl_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0 up: cmd[1:0].
    input  logic [ipacl_pkg::CMD_W-1:0]       s_tuser,
    // m_tdata fields from bit 0 up: allowed, verdict[1:0], hit_index[3:0], zero fill.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ipacl_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int IW    = (IDX_W > ipacl_pkg::SLOT_W) ? IDX_W : ipacl_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULES - 1);

    // Unpacked input fields.
    logic [ipacl_pkg::CMD_W-1:0]  in_cmd;
    logic [ipacl_pkg::SLOT_W-1:0] in_rule_index;
    logic [63:0]                  in_addr_hi;
    logic [63:0]                  in_addr_lo;
    logic [63:0]                  in_mask_hi;
    logic [63:0]                  in_mask_lo;
    logic                         in_use_prefix;
    logic [ipacl_pkg::PLEN_W-1:0] in_prefix_len;
    logic                         in_rule_is_ipv4;
    logic                         in_rule_allow;
    logic                         in_rule_all_scope;
    logic                         in_query_all_scope;

    assign in_cmd             = s_tuser;
    assign in_rule_index      = s_tdata[3:0];
    assign in_addr_hi         = s_tdata[67:4];
    assign in_addr_lo         = s_tdata[131:68];
    assign in_mask_hi         = s_tdata[195:132];
    assign in_mask_lo         = s_tdata[259:196];
    assign in_use_prefix      = s_tdata[260];
    assign in_prefix_len      = s_tdata[268:261];
    assign in_rule_is_ipv4    = s_tdata[269];
    assign in_rule_allow      = s_tdata[270];
    assign in_rule_all_scope  = s_tdata[271];
    assign in_query_all_scope = s_tdata[272];

    // Sequencer and tracking state.
    ipacl_pkg::state_t             state_reg, state_next;
    logic [RULES-1:0]              valid_reg, valid_next;
    logic [IDX_W-1:0]              scan_idx_reg, scan_idx_next;
    logic                          issue_reg, issue_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                          cmp_last_reg, cmp_last_next;
    logic                          cmp_slotv_reg, cmp_slotv_next;
    logic [ipacl_pkg::ADDR_W-1:0]  q_addr_reg, q_addr_next;
    logic                          q_all_reg, q_all_next;
    logic                          allow_hit_reg, allow_hit_next;
    logic [IDX_W-1:0]              allow_at_reg, allow_at_next;
    logic                          deny_hit_reg, deny_hit_next;
    logic [IDX_W-1:0]              deny_at_reg, deny_at_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    ipacl_pkg::result_t            res_reg, res_next;

    logic                          s_fire;
    logic [IW-1:0]                 wr_idx_ext;
    logic                          wr_in_range;
    logic                          wr_en;
    ipacl_pkg::rule_t              wr_rule;
    logic                          rd_en;
    ipacl_pkg::rule_t              rd_rule;
    logic                          rule_hit;
    ipacl_pkg::result_t            final_res;

    assign s_tready = (state_reg == ipacl_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Rule write path: slots past the end of the table are dropped.
    assign wr_idx_ext  = IW'(in_rule_index);
    assign wr_in_range = ({1'b0, wr_idx_ext} < (IW + 1)'(RULES));
    assign wr_en       = s_fire && (in_cmd == ipacl_pkg::CMD_WRITE) && wr_in_range;

    always_comb begin
        wr_rule.addr      = {in_addr_hi, in_addr_lo};
        wr_rule.mask      = in_use_prefix
                          ? ipacl_pkg::prefix_mask(in_prefix_len, in_rule_is_ipv4)
                          : {in_mask_hi, in_mask_lo};
        wr_rule.is_ipv4   = in_rule_is_ipv4;
        wr_rule.allow     = in_rule_allow;
        wr_rule.all_scope = in_rule_all_scope;
    end

    ipacl_rule_mem #(
        .RULES (RULES),
        .IDX_W (IDX_W)
    ) u_rule_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_ext[IDX_W-1:0]),
        .wr_data (wr_rule),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_rule)
    );

    ipacl_match u_match (
        .rule       (rd_rule),
        .query      (q_addr_reg),
        .slot_valid (cmp_slotv_reg),
        .only_all   (q_all_reg),
        .hit        (rule_hit)
    );

    // The first allow hit decides; failing that, the first deny hit; else default allow.
    always_comb begin
        if (allow_hit_reg) begin
            final_res.allowed   = 1'b1;
            final_res.verdict   = ipacl_pkg::VERDICT_ALLOW;
            final_res.hit_index = ipacl_pkg::HIT_W'(allow_at_reg);
        end else if (deny_hit_reg) begin
            final_res.allowed   = 1'b0;
            final_res.verdict   = ipacl_pkg::VERDICT_DENY;
            final_res.hit_index = ipacl_pkg::HIT_W'(deny_at_reg);
        end else begin
            final_res.allowed   = 1'b1;
            final_res.verdict   = ipacl_pkg::VERDICT_DEFAULT;
            final_res.hit_index = '0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        scan_idx_next  = scan_idx_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        cmp_last_next  = cmp_last_reg;
        cmp_slotv_next = cmp_slotv_reg;
        q_addr_next    = q_addr_reg;
        q_all_next     = q_all_reg;
        allow_hit_next = allow_hit_reg;
        allow_at_next  = allow_at_reg;
        deny_hit_next  = deny_hit_reg;
        deny_at_next   = deny_at_reg;
        m_tvalid_next  = m_tvalid_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;

        // The output register empties independently of the sequencer.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ipacl_pkg::ST_IDLE: begin
                if (s_fire) begin
                    allow_hit_next = 1'b0;
                    deny_hit_next  = 1'b0;
                    allow_at_next  = '0;
                    deny_at_next   = '0;
                    q_addr_next    = {in_addr_hi, in_addr_lo};
                    q_all_next     = in_query_all_scope;
                    state_next     = ipacl_pkg::ST_DONE;
                    case (in_cmd)
                        ipacl_pkg::CMD_CLEAR: begin
                            valid_next = '0;
                        end
                        ipacl_pkg::CMD_WRITE: begin
                            if (wr_in_range) begin
                                valid_next[wr_idx_ext[IDX_W-1:0]] = 1'b1;
                            end
                        end
                        ipacl_pkg::CMD_CHECK: begin
                            scan_idx_next = '0;
                            issue_next    = 1'b1;
                            state_next    = ipacl_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ipacl_pkg::ST_SCAN: begin
                // Read stage: fetch one rule per cycle.
                if (issue_reg) begin
                    rd_en          = 1'b1;
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    cmp_last_next  = (scan_idx_reg == LAST_IDX);
                    cmp_slotv_next = valid_reg[scan_idx_reg];
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                // Compare stage: keep the lowest matching allow and deny indexes.
                if (cmp_vld_reg) begin
                    if (rule_hit) begin
                        if (rd_rule.allow) begin
                            if (!allow_hit_reg) begin
                                allow_hit_next = 1'b1;
                                allow_at_next  = cmp_idx_reg;
                            end
                        end else if (!deny_hit_reg) begin
                            deny_hit_next = 1'b1;
                            deny_at_next  = cmp_idx_reg;
                        end
                    end
                    if (cmp_last_reg) begin
                        state_next = ipacl_pkg::ST_DONE;
                    end
                end
            end
            ipacl_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    res_next      = final_res;
                    state_next    = ipacl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ipacl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ipacl_pkg::ST_IDLE;
            valid_reg     <= '0;
            issue_reg     <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            allow_hit_reg <= 1'b0;
            deny_hit_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
            allow_hit_reg <= allow_hit_next;
            deny_hit_reg  <= deny_hit_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        cmp_last_reg  <= cmp_last_next;
        cmp_slotv_reg <= cmp_slotv_next;
        q_addr_reg    <= q_addr_next;
        q_all_reg     <= q_all_next;
        allow_at_reg  <= allow_at_next;
        deny_at_reg   <= deny_at_next;
        res_reg       <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.hit_index, res_reg.verdict, res_reg.allowed};

endmodule

FILE: tb/ip_allow_deny_access_list_tb.sv
// Self-checking testbench for the IP allow/deny access list with prefix matching.
`timescale 1ns / 1ps

module ip_allow_deny_access_list_tb;

    localparam int RULE_SLOTS = 16;
    // A check walks every slot, plus the accept and result steps.
    localparam int CHECK_LAT = RULE_SLOTS + 3;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [ipacl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One input transfer, unpacked for readability.
    typedef struct {
        logic [ipacl_pkg::CMD_W-1:0]  cmd;
        logic [ipacl_pkg::SLOT_W-1:0] rule_index;
        logic [63:0]                  addr_hi;
        logic [63:0]                  addr_lo;
        logic [63:0]                  mask_hi;
        logic [63:0]                  mask_lo;
        logic                         use_prefix;
        logic [ipacl_pkg::PLEN_W-1:0] prefix_len;
        logic                         is_ipv4;
        logic                         allow;
        logic                         all_scope;
        logic                         query_all;
    } acl_cmd_t;

    // Shadow copy of the rule table and the queue of verdicts still owed by the block.
    class verdict_tracker;
        bit                 slot_used[RULE_SLOTS];
        logic [127:0]       rule_addr[RULE_SLOTS];
        logic [127:0]       rule_mask[RULE_SLOTS];
        bit                 rule_v4[RULE_SLOTS];
        bit                 rule_allow[RULE_SLOTS];
        bit                 rule_all[RULE_SLOTS];
        ipacl_pkg::result_t pending_verdicts[$];
        int                 errors;

        function logic [127:0] lead_mask(int n);
            logic [127:0] ones;
            ones = '1;
            if (n <= 0) return '0;
            return ones << (128 - n);
        endfunction

        function bit rule_hits(int r, logic [127:0] q);
            logic [127:0] diff;
            diff = (rule_addr[r] ^ q) & rule_mask[r];
            return rule_v4[r] ? (diff[127:96] == 32'd0) : (diff == 128'd0);
        endfunction

        function void note_command(acl_cmd_t c);
            ipacl_pkg::result_t v;
            int                 n;
            int                 lim;
            bit                 allow_seen;
            bit                 deny_seen;
            int                 allow_at;
            int                 deny_at;
            logic [127:0]       q;
            v.allowed   = 1'b1;
            v.verdict   = ipacl_pkg::VERDICT_DEFAULT;
            v.hit_index = '0;
            case (c.cmd)
                ipacl_pkg::CMD_CLEAR: begin
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                end
                ipacl_pkg::CMD_WRITE: begin
                    if (int'(c.rule_index) < RULE_SLOTS) begin
                        rule_addr[c.rule_index] = {c.addr_hi, c.addr_lo};
                        if (c.use_prefix) begin
                            lim = c.is_ipv4 ? 32 : 128;
                            n = (int'(c.prefix_len) > lim) ? lim : int'(c.prefix_len);
                            rule_mask[c.rule_index] = lead_mask(n);
                        end else begin
                            rule_mask[c.rule_index] = {c.mask_hi, c.mask_lo};
                        end
                        rule_v4[c.rule_index]    = c.is_ipv4;
                        rule_allow[c.rule_index] = c.allow;
                        rule_all[c.rule_index]   = c.all_scope;
                        slot_used[c.rule_index]  = 1'b1;
                    end
                end
                ipacl_pkg::CMD_CHECK: begin
                    q = {c.addr_hi, c.addr_lo};
                    allow_seen = 1'b0;
                    deny_seen  = 1'b0;
                    allow_at   = 0;
                    deny_at    = 0;
                    for (int r = 0; r < RULE_SLOTS; r++) begin
                        if (slot_used[r] && (!c.query_all || rule_all[r]) && rule_hits(r, q)) begin
                            if (rule_allow[r]) begin
                                if (!allow_seen) begin
                                    allow_seen = 1'b1;
                                    allow_at   = r;
                                end
                            end else if (!deny_seen) begin
                                deny_seen = 1'b1;
                                deny_at   = r;
                            end
                        end
                    end
                    if (allow_seen) begin
                        v.verdict   = ipacl_pkg::VERDICT_ALLOW;
                        v.hit_index = ipacl_pkg::HIT_W'(allow_at);
                    end else if (deny_seen) begin
                        v.allowed   = 1'b0;
                        v.verdict   = ipacl_pkg::VERDICT_DENY;
                        v.hit_index = ipacl_pkg::HIT_W'(deny_at);
                    end
                end
                default: ;
            endcase
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [ipacl_pkg::M_DATA_W-1:0] word);
            ipacl_pkg::result_t want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (word[0] !== want.allowed) begin
                $display("%0t: allowed expected %0d actual %0d", $time, want.allowed, word[0]);
                errors++;
            end
            if (word[2:1] !== want.verdict) begin
                $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, word[2:1]);
                errors++;
            end
            if (word[6:3] !== want.hit_index) begin
                $display("%0t: hit_index expected %0d actual %0d", $time, want.hit_index,
                         word[6:3]);
                errors++;
            end
        endfunction
    endclass

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [ipacl_pkg::S_DATA_W-1:0]     s_tdata;
    logic [ipacl_pkg::CMD_W-1:0]        s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [ipacl_pkg::M_DATA_W-1:0]     m_tdata;

    verdict_tracker board = new();
    acl_cmd_t       s_item;        // the item currently presented on the input channel
    int             items_sent;
    int             cycle_count;

    // Stimulus-side memory of written rules, used only to aim checks at real rules.
    bit             gen_written[RULE_SLOTS];
    logic [127:0]   gen_addr[RULE_SLOTS];
    int             gen_keep[RULE_SLOTS];

    ip_allow_deny_access_list #(
        .RULES(RULE_SLOTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // In every 150 transfers the last 30 run on both sides with no idle cycles at all.
    function automatic int idle_draw();
        if ((items_sent % 150) >= 120) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Packs the fields into tdata, rule_index at bit 0, zero fill at the top.
    function automatic logic [ipacl_pkg::S_DATA_W-1:0] pack_command(acl_cmd_t c);
        return {7'd0, c.query_all, c.all_scope, c.allow, c.is_ipv4, c.prefix_len,
                c.use_prefix, c.mask_lo, c.mask_hi, c.addr_lo, c.addr_hi, c.rule_index};
    endfunction

    // All fields but cmd random so that every bit toggles; prefix lengths lean toward the
    // family boundaries, where clamping and word splits happen.
    function automatic acl_cmd_t random_item();
        acl_cmd_t c;
        c.cmd        = ipacl_pkg::CMD_CHECK;
        c.rule_index = ipacl_pkg::SLOT_W'($urandom_range(0, RULE_SLOTS - 1));
        c.addr_hi    = {$urandom, $urandom};
        c.addr_lo    = {$urandom, $urandom};
        c.mask_hi    = {$urandom, $urandom};
        c.mask_lo    = {$urandom, $urandom};
        c.use_prefix = 1'($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0: c.prefix_len = 8'd0;
            1: c.prefix_len = 8'd31;
            2: c.prefix_len = 8'd32;
            3: c.prefix_len = 8'd33;
            4: c.prefix_len = 8'd64;
            5: c.prefix_len = 8'd65;
            6: c.prefix_len = 8'd128;
            default: c.prefix_len = 8'($urandom_range(0, 128));
        endcase
        c.is_ipv4    = 1'($urandom_range(0, 1));
        c.allow      = 1'($urandom_range(0, 1));
        c.all_scope  = 1'($urandom_range(0, 1));
        c.query_all  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic acl_cmd_t rule_write(int slot, logic [63:0] a_hi, logic [63:0] a_lo,
                                            logic [63:0] m_hi, logic [63:0] m_lo, bit use_p,
                                            int plen, bit v4, bit allow, bit all);
        acl_cmd_t c;
        c            = random_item();
        c.cmd        = ipacl_pkg::CMD_WRITE;
        c.rule_index = ipacl_pkg::SLOT_W'(slot);
        c.addr_hi    = a_hi;
        c.addr_lo    = a_lo;
        c.mask_hi    = m_hi;
        c.mask_lo    = m_lo;
        c.use_prefix = use_p;
        c.prefix_len = ipacl_pkg::PLEN_W'(plen);
        c.is_ipv4    = v4;
        c.allow      = allow;
        c.all_scope  = all;
        return c;
    endfunction

    function automatic acl_cmd_t addr_check(logic [63:0] a_hi, logic [63:0] a_lo, bit all);
        acl_cmd_t c;
        c           = random_item();
        c.cmd       = ipacl_pkg::CMD_CHECK;
        c.addr_hi   = a_hi;
        c.addr_lo   = a_lo;
        c.query_all = all;
        return c;
    endfunction

    // Presents one item after a random gap and waits for the transfer. The valid is
    // left high when the next item follows with no gap, so it is never lowered and
    // raised in the same time step.
    task automatic send_command(input acl_cmd_t c);
        int gap;
        int lim;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_command(c);
        s_tuser  <= c.cmd;
        s_item   <= c;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (c.cmd == ipacl_pkg::CMD_CLEAR) begin
            foreach (gen_written[i]) gen_written[i] = 1'b0;
        end else if (c.cmd == ipacl_pkg::CMD_WRITE) begin
            lim = c.is_ipv4 ? 32 : 128;
            gen_written[c.rule_index] = 1'b1;
            gen_addr[c.rule_index]    = {c.addr_hi, c.addr_lo};
            gen_keep[c.rule_index]    = (c.use_prefix && int'(c.prefix_len) < lim) ?
                                        int'(c.prefix_len) : lim;
        end
    endtask

    // Both channels are sampled at the rising edge, before the edge's own updates land.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_command(s_item);
        if (aresetn && m_tvalid && m_tready) board.check_verdict(m_tdata);
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     board.pending_verdicts.size());
            $display("ip_allow_deny_access_list_tb: done, errors");
            $finish;
        end
    end

    // Result side. It stalls a random number of cycles before each result, and twice
    // holds off for a long stretch so that a result sits in the output register, the
    // next one completes behind it and the block has to refuse input transfers.
    initial begin
        int hold;
        int taken;
        taken = 0;
        m_tready <= 1'b0;
        repeat (5) @(posedge aclk);
        forever begin
            if (taken == 60 || taken == 800) hold = 400;
            else hold = idle_draw();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Input side: reset, a directed pass over the special cases, then random traffic.
    initial begin
        acl_cmd_t     c;
        int           op;
        int           slot;
        bit           any_rule;
        logic [127:0] q;
        items_sent  = 0;
        cycle_count = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ipacl_pkg::CMD_CLEAR;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: everything is allowed by default.
        send_command(addr_check('1, '1, 1'b0));
        // IPv4 deny 10.1.2.0/24 in the lowest slot, then a hit on it.
        send_command(rule_write(0, 64'h0A01_0200_0000_0000, 64'd0, '1, '1, 1'b1, 24,
                                1'b1, 1'b0, 1'b0));
        send_command(addr_check(64'h0A01_024D_FFFF_FFFF, '1, 1'b0));
        // IPv4 allow with a prefix above 32, which clamps to a host rule, in the top
        // slot; the allow wins over the lower deny.
        send_command(rule_write(15, 64'h0A01_024D_0000_0000, '1, '0, '0, 1'b1, 40,
                                1'b1, 1'b1, 1'b1));
        send_command(addr_check(64'h0A01_024D_1234_5678, 64'd0, 1'b0));
        // Apply-all check: the deny is not an apply-all rule and the allow misses.
        send_command(addr_check(64'h0A01_0205_0000_0000, 64'd0, 1'b1));
        // IPv6 host rule, all ones, full 128-bit prefix.
        send_command(rule_write(3, '1, '1, '0, '0, 1'b1, 128, 1'b0, 1'b1, 1'b0));
        send_command(addr_check('1, '1, 1'b0));
        send_command(addr_check('1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0));
        // IPv6 deny with a zero prefix matches every address.
        send_command(rule_write(4, '0, '0, '1, '1, 1'b1, 0, 1'b0, 1'b0, 1'b1));
        send_command(addr_check('0, '0, 1'b1));
        // IPv4 allow with an explicit mask; the low address word never matters.
        send_command(rule_write(5, '0, '1, 64'hFFFF_FFFF_0000_0000, '0, 1'b0, 128,
                                1'b1, 1'b1, 1'b1));
        send_command(addr_check(64'h0000_0000_ABCD_EF01, '0, 1'b1));
        // IPv6 /65: the mask crosses into the low word by one bit.
        send_command(rule_write(6, 64'h2001_0DB8_0000_0000, '0, '1, '1, 1'b1, 65,
                                1'b0, 1'b1, 1'b0));
        send_command(addr_check(64'h2001_0DB8_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
        send_command(addr_check(64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000, 1'b0));
        // The unused command code changes nothing and answers like a write.
        c = random_item();
        c.cmd = CMD_UNUSED;
        send_command(c);
        send_command(addr_check('1, '1, 1'b0));
        // Clear empties the table.
        c = random_item();
        c.cmd = ipacl_pkg::CMD_CLEAR;
        send_command(c);
        send_command(addr_check('1, '1, 1'b0));
        // IPv4 /32 deny after the clear.
        send_command(rule_write(9, 64'hC0A8_0001_0000_0000, '0, '0, '0, 1'b1, 32,
                                1'b1, 1'b0, 1'b1));
        send_command(addr_check(64'hC0A8_0001_5555_5555, '1, 1'b1));
        send_command(addr_check(64'hC0A8_0002_0000_0000, '0, 1'b1));

        // Random traffic, mostly writes and checks aimed at stored rules.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            c  = random_item();
            op = $urandom_range(0, 99);
            any_rule = 1'b0;
            foreach (gen_written[i]) any_rule |= gen_written[i];
            if (op < 2) begin
                c.cmd = CMD_UNUSED;
            end else if (op < 5) begin
                c.cmd = ipacl_pkg::CMD_CLEAR;
            end else if (op < 38) begin
                c.cmd = ipacl_pkg::CMD_WRITE;
                if (!c.use_prefix) begin
                    case ($urandom_range(0, 3))
                        0: ;
                        1: {c.mask_hi, c.mask_lo} = {128{1'b1}} << $urandom_range(0, 128);
                        2: {c.mask_hi, c.mask_lo} = '1;
                        default: {c.mask_hi, c.mask_lo} = rand128() & rand128() & rand128();
                    endcase
                end
            end else begin
                c.cmd = ipacl_pkg::CMD_CHECK;
                if (any_rule && $urandom_range(0, 4) != 0) begin
                    // Keep the rule's leading bits, scramble the rest, and now and
                    // then flip one random bit, which can land the query just outside the rule.
                    do slot = $urandom_range(0, RULE_SLOTS - 1); while (!gen_written[slot]);
                    q = gen_addr[slot] ^ (rand128() >> gen_keep[slot]);
                    if ($urandom_range(0, 3) == 0) q[$urandom_range(0, 127)] ^= 1'b1;
                    {c.addr_hi, c.addr_lo} = q;
                end
            end
            send_command(c);
        end
        s_tvalid <= 1'b0;

        while (board.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (2 * CHECK_LAT) @(posedge aclk);
        if (board.pending_verdicts.size() != 0) begin
            $display("%0t: results expected %0d more, actual none", $time,
                     board.pending_verdicts.size());
        end
        if (board.errors == 0 && board.pending_verdicts.size() == 0)
            $display("ip_allow_deny_access_list_tb: done, clean");
        else
            $display("ip_allow_deny_access_list_tb: done, errors");
        $finish;
    end

endmodule
